### hdl/b64fd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64fd_pkg
// Shared types and constants for the base64 frame deframer with checksum.
// ---------------------------------------------------------------------------
package b64fd_pkg;

	localparam logic [7:0] FRAME_DELIM = 8'hFF;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_EMPTY    = 2'd3
	} kind_t;

	// one decoded character: valid flag and its 6-bit value
	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.hit   = 1'b1;
		s.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s.value = 6'd62;
		end else if (c == 8'h2F) begin
			s.value = 6'd63;
		end else begin
			s.hit = 1'b0;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

### hdl/base64_frame_deframer_checksum_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// base64_frame_deframer_checksum_core
// Decodes base64 characters into bytes, holds back the last byte of each
// frame as an additive checksum and reports frame status at 0xFF.
// ---------------------------------------------------------------------------
// One received byte is taken per word and a new word can be accepted every
// clock cycle unless the word in the input register makes a result while
// the result register is full and unread. Each word then passes the decode
// and checksum logic into the result register. Bytes that are not base64
// characters (including '=') are dropped without a result; decoded bytes
// come out one position late, the final decoded byte of a frame being compared
// against the 8-bit wrapping sum of the earlier ones. The delimiter gives a
// status word with frame_end set: kind 1 good, 2 mismatch, 3 empty frame.
module base64_frame_deframer_checksum_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] payload_byte,
	output logic [1:0] kind,
	output logic       frame_end
);
	import b64fd_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] rx_s1;

	// decode state
	logic [5:0] bit_buf_q;
	logic [2:0] bit_cnt_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [7:0] sum_q;

	// result register
	logic       out_valid_q;
	logic [7:0] payload_q;
	kind_t      kind_q;
	logic       frame_end_q;

	sextet_t     sx;
	logic        is_delim;
	logic [11:0] buf_wide;
	logic [2:0]  cnt_rem;
	logic        byte_done;
	logic [7:0]  decoded;
	logic [5:0]  rem_mask;
	logic        makes_result;
	logic        out_free;
	logic        advance;
	kind_t       end_kind;

	always_comb begin
		sx        = sextet_of(rx_s1);
		is_delim  = (rx_s1 == FRAME_DELIM);
		buf_wide  = {bit_buf_q, sx.value};
		byte_done = (bit_cnt_q != 3'd0);
		cnt_rem   = bit_cnt_q - 3'd2;
		decoded   = 8'(buf_wide >> cnt_rem);
		rem_mask  = 6'((7'd1 << cnt_rem) - 7'd1);
		if (!held_valid_q) begin
			end_kind = KIND_EMPTY;
		end else if (held_byte_q == sum_q) begin
			end_kind = KIND_GOOD;
		end else begin
			end_kind = KIND_MISMATCH;
		end
		makes_result = is_delim || (sx.hit && byte_done && held_valid_q);
		out_free     = !out_valid_q || out_ready;
		advance      = valid_s1 && (!makes_result || out_free);
		in_ready     = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_buf_q    <= '0;
			bit_cnt_q    <= '0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			sum_q        <= '0;
		end else if (advance) begin
			if (is_delim) begin
				bit_buf_q    <= '0;
				bit_cnt_q    <= '0;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				sum_q        <= '0;
			end else if (sx.hit) begin
				if (!byte_done) begin
					bit_buf_q <= sx.value;
					bit_cnt_q <= 3'd6;
				end else begin
					bit_buf_q    <= buf_wide[5:0] & rem_mask;
					bit_cnt_q    <= cnt_rem;
					held_byte_q  <= decoded;
					held_valid_q <= 1'b1;
					if (held_valid_q) begin
						sum_q <= sum_q + held_byte_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && makes_result) begin
			if (is_delim) begin
				payload_q   <= 8'd0;
				kind_q      <= end_kind;
				frame_end_q <= 1'b1;
			end else begin
				payload_q   <= held_byte_q;
				kind_q      <= KIND_PAYLOAD;
				frame_end_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign kind         = kind_q;
	assign frame_end    = frame_end_q;

`ifndef SYNTHESIS
	// leftover bit count is always an even number up to six
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_cnt_q[0] == 1'b0) && (bit_cnt_q <= 3'd6))
		else $error("bit count out of range");

	// status words and only status words end a frame
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (frame_end_q == (kind_q != KIND_PAYLOAD)))
		else $error("frame_end disagrees with kind");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> (payload_q == 8'd0))
		else $error("status word carries payload");

	// a delimiter leaves the decoder empty
	a_delim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_delim) |=> (!held_valid_q && bit_cnt_q == 3'd0 && sum_q == 8'd0))
		else $error("state not cleared after delimiter");
`endif

endmodule
`default_nettype wire

### tb/b64_deframe_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_deframe_checker
// Watches both word channels of the base64 deframer, predicts each result
// from the accepted input words and compares the results in order.
// ---------------------------------------------------------------------------
module b64_deframe_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire  [7:0] rx_byte,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire  [7:0] payload_byte,
	input  wire  [1:0] kind,
	input  wire        frame_end,
	output int         mismatches,
	output int         outstanding,
	output int         words_checked,
	output int         frames_good,
	output int         frames_bad,
	output int         frames_empty
);
	import b64fd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} deframed_t;

	deframed_t deframed_q[$];
	deframed_t want;

	// decoder copy: partial bits, held-back byte and payload sum
	logic [13:0] acc_bits;
	logic [3:0]  acc_count;
	logic [7:0]  held_back;
	logic        held_back_ok;
	logic [7:0]  payload_sum;

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		words_checked = 0;
		frames_good   = 0;
		frames_bad    = 0;
		frames_empty  = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// 6-bit value of a base64 character, -1 when the byte is skipped
	function automatic int char_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return int'(c) - int'("A");
		if (c >= "a" && c <= "z")
			return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0") + 52;
		if (c == "+")
			return 62;
		if (c == "/")
			return 63;
		return -1;
	endfunction

	task automatic clear_decoder();
		acc_bits     = '0;
		acc_count    = '0;
		held_back    = '0;
		held_back_ok = 1'b0;
		payload_sum  = '0;
	endtask

	task automatic predict_word(input logic [7:0] c);
		deframed_t r;
		int v;
		logic [7:0] got;
		v = char_value(c);
		if (c == FRAME_DELIM) begin
			r.data = 8'h00;
			r.last = 1'b1;
			if (!held_back_ok)
				r.kind = KIND_EMPTY;
			else if (held_back == payload_sum)
				r.kind = KIND_GOOD;
			else
				r.kind = KIND_MISMATCH;
			deframed_q.push_back(r);
			clear_decoder();
		end else if (v >= 0) begin
			acc_bits  = {acc_bits[7:0], 6'(v)};
			acc_count = acc_count + 4'd6;
			if (acc_count >= 4'd8) begin
				acc_count = acc_count - 4'd8;
				got       = 8'(acc_bits >> acc_count);
				acc_bits  = acc_bits & ((14'd1 << acc_count) - 14'd1);
				if (held_back_ok) begin
					r.data = held_back;
					r.kind = KIND_PAYLOAD;
					r.last = 1'b0;
					deframed_q.push_back(r);
					payload_sum = payload_sum + held_back;
				end
				held_back    = got;
				held_back_ok = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			deframed_q.delete();
			outstanding = 0;
		end else begin
			// results first: a word accepted at this edge cannot have caused one yet
			if (out_valid && out_ready) begin
				words_checked++;
				if (deframed_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%02h kind=%0d end=%0b",
						payload_byte, kind, frame_end));
				end else begin
					want = deframed_q.pop_front();
					if (payload_byte !== want.data)
						report_mismatch($sformatf("payload_byte got %02h want %02h",
							payload_byte, want.data));
					if (kind !== want.kind)
						report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
					if (frame_end !== want.last)
						report_mismatch($sformatf("frame_end got %0b want %0b",
							frame_end, want.last));
					case (want.kind)
						KIND_GOOD:     frames_good++;
						KIND_MISMATCH: frames_bad++;
						KIND_EMPTY:    frames_empty++;
						default:       ;
					endcase
				end
			end
			if (in_valid && in_ready)
				predict_word(rx_byte);
			outstanding = deframed_q.size();
		end
	end

endmodule

### tb/base64_frame_deframer_checksum_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_frame_deframer_checksum_core_test
// Feeds base64-encoded frames with good and bad checksums, padding, noise
// and truncated frames into the deframer under random flow control.
// ---------------------------------------------------------------------------
module base64_frame_deframer_checksum_core_test;
	import b64fd_pkg::*;

	localparam int STUCK_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_WORDS  = 1100;
	localparam int DRAIN_CYCLES  = 10;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_ready = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire  [7:0] payload_byte;
	wire  [1:0] kind;
	wire        frame_end;

	int mismatches, outstanding, words_checked;
	int frames_good, frames_bad, frames_empty;

	int send_idle_pct = 21;
	int take_idle_pct = 21;
	bit hold_off_req  = 1'b0;
	int words_sent    = 0;
	int live_words    = 0;
	int frames_sent   = 0;
	int stuck_cycles  = 0;

	string b64_chars =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	base64_frame_deframer_checksum_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.kind         (kind),
		.frame_end    (frame_end)
	);

	b64_deframe_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.kind          (kind),
		.frame_end     (frame_end),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.frames_good   (frames_good),
		.frames_bad    (frames_bad),
		.frames_empty  (frames_empty)
	);

	always #10 clk = ~clk;

	function automatic bit is_b64_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			(c >= "0" && c <= "9") || c == "+" || c == "/";
	endfunction

	// any byte the decoder skips: padding, controls, 0x80..0xfe
	function automatic logic [7:0] pick_noise();
		logic [7:0] c;
		do
			c = 8'($urandom_range(254));
		while (is_b64_char(c));
		return c;
	endfunction

	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (b == FRAME_DELIM || is_b64_char(b))
			live_words++;
		@(negedge clk);
	endtask

	// one frame: payload, checksum byte, base64 text, optional padding,
	// noise, truncation, then the delimiter
	task automatic send_frame();
		logic [7:0] bytes_q[$];
		logic [7:0] chars_q[$];
		logic [7:0] sum;
		logic [15:0] acc;
		int nbits, n_pay, cut, roll;
		sum = 8'h00;
		roll = $urandom_range(99);
		if (roll < 8)
			n_pay = -1;
		else if (roll < 88)
			n_pay = $urandom_range(8);
		else
			n_pay = $urandom_range(40, 9);
		for (int i = 0; i < n_pay; i++) begin
			bytes_q.push_back(8'($urandom));
			sum = sum + bytes_q[$];
		end
		if (n_pay >= 0) begin
			if ($urandom_range(99) < 20)
				bytes_q.push_back(sum ^ 8'($urandom_range(255, 1)));
			else
				bytes_q.push_back(sum);
		end
		acc = '0;
		nbits = 0;
		foreach (bytes_q[i]) begin
			acc = {acc[7:0], bytes_q[i]};
			nbits += 8;
			while (nbits >= 6) begin
				nbits -= 6;
				chars_q.push_back(b64_chars[int'((acc >> nbits) & 16'h3f)]);
			end
		end
		if (nbits > 0) begin
			chars_q.push_back(b64_chars[int'((acc << (6 - nbits)) & 16'h3f)]);
			if ($urandom_range(1) == 1)
				while (chars_q.size() % 4 != 0)
					chars_q.push_back("=");
		end
		// broken frame: drop one or two trailing characters
		if (chars_q.size() > 0 && $urandom_range(99) < 8) begin
			cut = $urandom_range(2, 1);
			while (cut > 0 && chars_q.size() > 0) begin
				void'(chars_q.pop_back());
				cut--;
			end
		end
		foreach (chars_q[i]) begin
			if ($urandom_range(99) < 5)
				send_word(pick_noise());
			send_word(chars_q[i]);
		end
		send_word(FRAME_DELIM);
		frames_sent++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
			$display("no word moved for %0d cycles, %0d results still due",
				STUCK_LIMIT, outstanding);
			$display("Test completed with failures");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		logic [7:0] directed_q[$];
		directed_q = '{
			FRAME_DELIM, FRAME_DELIM,
			"=", 8'h00, 8'h80, 8'hFE, FRAME_DELIM,
			"A", "A", FRAME_DELIM,
			"/", "w", FRAME_DELIM,
			"A", "Q", "E", "=", FRAME_DELIM,
			"+", "Z", "a", "z", "0", "9", FRAME_DELIM
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty frames, skipped bytes, single-byte checksums, leftover bits
		foreach (directed_q[i])
			send_word(directed_q[i]);

		// back-to-back stretch with no idling on either side
		send_idle_pct = 0;
		take_idle_pct = 0;
		while (live_words < 300)
			send_frame();

		send_idle_pct = 21;
		take_idle_pct = 21;
		hold_off_req  = 1'b1;
		while (live_words < RANDOM_WORDS + 25) begin
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(6, 1)) send_word(pick_noise());
			send_frame();
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words (%0d decoded or delimiters) in %0d frames",
			words_sent, live_words, frames_sent);
		$display("checked %0d results: %0d good, %0d bad checksum, %0d empty frames",
			words_checked, frames_good, frames_bad, frames_empty);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
